[sv/lps_pkg.sv]
package lps_pkg;

  // Sizes of the sieve stores.
  localparam int unsigned MAX_NUMBER  = 65536;
  localparam int unsigned PRIME_DEPTH = 8192;

  // Fixed field widths.
  localparam int unsigned NUM_W = 16;
  localparam int unsigned IDX_W = 13;
  localparam int unsigned TOT_W = 14;

  // Derived store widths.
  localparam int unsigned MAP_AW = $clog2(MAX_NUMBER);
  localparam int unsigned PL_AW  = $clog2(PRIME_DEPTH);
  localparam int unsigned CNT_W  = $clog2(PRIME_DEPTH + 1);

  localparam logic [NUM_W-1:0] LIMIT_RESET = 16'hFFFF;
  localparam logic [NUM_W:0]   FIRST_CAND  = 17'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic check;
    logic fetch;
    logic mul;
    logic mark;
    logic step;
    logic finish;
  } lps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic seq_err;
    logic walk_end;
    logic prod_over;
    logic rem_done;
    logic rem_zero;
    logic out_free;
  } lps_status_t;

endpackage

[sv/linear_prime_sieve_top.sv]
// Channel   Direction  Transaction carries
// s_axis    in         candidate number
// m_axis    out        one result per candidate
// cfg       in         sieve_limit write, no read-back
//
// An item in sequence walks the stored primes (list read, multiply, mark,
// bit-serial remainder for each tested prime) until the walk runs off the
// list, the product passes sieve_limit or a stored prime divides it.
// After reset the composite bitmap is cleared one entry a cycle, which
// keeps s_axis_tready_o low until all MAX_NUMBER (65536) entries are clear.
// A result waiting on m_axis only holds the next item in its finish state.
module linear_prime_sieve_top import lps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] candidate
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [15:0] number_out, [28:16] prime_index,
                                        // [42:29] prime_total, [43] sequence_error,
                                        // [44] list_full, [47:45] zero
  output logic        m_axis_tuser_o,   // [0] is_prime
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  lps_cmd_t    cmd;
  lps_status_t status;

  logic [NUM_W-1:0] number_out;
  logic             is_prime;
  logic [IDX_W-1:0] prime_index;
  logic [TOT_W-1:0] prime_total;
  logic             sequence_error;
  logic             list_full;

  lps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lps_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cand_i           (s_axis_tdata_i),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .number_out_o     (number_out),
    .is_prime_o       (is_prime),
    .prime_index_o    (prime_index),
    .prime_total_o    (prime_total),
    .sequence_error_o (sequence_error),
    .list_full_o      (list_full)
  );

  assign m_axis_tdata_o = {3'b000, list_full, sequence_error, prime_total,
                           prime_index, number_out};
  assign m_axis_tuser_o = is_prime;

endmodule

[sv/lps_rem.sv]
module lps_rem import lps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [NUM_W-1:0] divisor_i,
  output logic             done_o,
  output logic             zero_o
);

  localparam int unsigned CW = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] dvd_q, dvd_d;
  logic [NUM_W-1:0] dvs_q, dvs_d;
  logic [NUM_W:0]   trial;
  logic [NUM_W:0]   diff;

  // One restoring step per cycle: bring down the next dividend bit and
  // subtract the divisor where it fits.
  assign trial = {rem_q, dvd_q[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CW'(NUM_W - 1);
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = diff[NUM_W] ? trial[NUM_W-1:0] : diff[NUM_W-1:0];
      dvd_d = {dvd_q[NUM_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == '0);

endmodule

[sv/lps_datapath.sv]
module lps_datapath import lps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lps_cmd_t         cmd_i,
  output lps_status_t      status_o,
  input  logic             cfg_we_i,
  input  logic [NUM_W-1:0] cfg_wdata_i,
  input  logic [NUM_W-1:0] cand_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [NUM_W-1:0] number_out_o,
  output logic             is_prime_o,
  output logic [IDX_W-1:0] prime_index_o,
  output logic [TOT_W-1:0] prime_total_o,
  output logic             sequence_error_o,
  output logic             list_full_o
);

  // Stores.
  logic             map_mem [MAX_NUMBER];
  logic [NUM_W-1:0] pl_mem  [PRIME_DEPTH];

  // Control state.
  logic [NUM_W-1:0]  limit_q;
  logic [NUM_W:0]    exp_q;
  logic [CNT_W-1:0]  count_q;
  logic [MAP_AW-1:0] clr_addr_q;
  logic              out_valid_q;

  // Per-item working registers.
  logic [NUM_W-1:0] cand_q;
  logic             seq_err_q;
  logic             map_rd_q;
  logic [NUM_W-1:0] pl_rd_q;
  logic [CNT_W-1:0] k_q;
  logic [31:0]      prod_q;
  logic             prime_q;
  logic [PL_AW-1:0] index_q;
  logic             full_q;

  // Result register.
  logic [NUM_W-1:0] res_num_q;
  logic             res_prime_q;
  logic [IDX_W-1:0] res_index_q;
  logic [TOT_W-1:0] res_total_q;
  logic             res_err_q;
  logic             res_full_q;

  logic [31:0]       cand_in_ext;
  logic [31:0]       cand_ext;
  logic              marked;
  logic              room;
  logic              store_prime;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr;
  logic              prod_in_map;
  logic              rem_done;
  logic              rem_zero;

  assign cand_in_ext = 32'(cand_i);
  assign cand_ext    = 32'(cand_q);
  // A candidate beyond the map reads as unmarked.
  assign marked      = map_rd_q && (cand_ext < 32'(MAX_NUMBER));
  assign room        = (count_q < CNT_W'(PRIME_DEPTH));
  assign store_prime = cmd_i.check && !seq_err_q && !marked && room;
  assign prod_in_map = (prod_q < 32'(MAX_NUMBER));

  assign map_we    = cmd_i.clear || (cmd_i.mark && prod_in_map);
  assign map_waddr = cmd_i.clear ? clr_addr_q : prod_q[MAP_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= !cmd_i.clear;
    end
    if (cmd_i.load) begin
      map_rd_q <= map_mem[cand_in_ext[MAP_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_prime) begin
      pl_mem[count_q[PL_AW-1:0]] <= cand_q;
    end
    if (cmd_i.fetch) begin
      pl_rd_q <= pl_mem[k_q[PL_AW-1:0]];
    end
  end

  lps_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mul),
    .dividend_i (cand_q),
    .divisor_i  (pl_rd_q),
    .done_o     (rem_done),
    .zero_o     (rem_zero)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      exp_q       <= FIRST_CAND;
      count_q     <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.check && !seq_err_q) begin
        exp_q <= exp_q + 1'b1;
      end
      if (store_prime) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cand_q    <= cand_i;
      seq_err_q <= ({1'b0, cand_i} != exp_q);
      prime_q   <= 1'b0;
      index_q   <= '0;
      full_q    <= 1'b0;
    end
    if (cmd_i.check) begin
      k_q <= '0;
      if (!seq_err_q && !marked) begin
        prime_q <= 1'b1;
        full_q  <= !room;
        if (room) begin
          index_q <= count_q[PL_AW-1:0];
        end
      end
    end
    if (cmd_i.step) begin
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.mul) begin
      prod_q <= {16'b0, cand_q} * {16'b0, pl_rd_q};
    end
    if (cmd_i.finish) begin
      res_num_q   <= cand_q;
      res_prime_q <= prime_q;
      res_index_q <= IDX_W'(index_q);
      res_total_q <= TOT_W'(count_q);
      res_err_q   <= seq_err_q;
      res_full_q  <= full_q;
    end
  end

  assign status_o.clear_last = (clr_addr_q == MAP_AW'(MAX_NUMBER - 1));
  assign status_o.seq_err    = seq_err_q;
  assign status_o.walk_end   = (k_q >= count_q);
  assign status_o.prod_over  = (prod_q > 32'(limit_q));
  assign status_o.rem_done   = rem_done;
  assign status_o.rem_zero   = rem_zero;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign number_out_o     = res_num_q;
  assign is_prime_o       = res_prime_q;
  assign prime_index_o    = res_index_q;
  assign prime_total_o    = res_total_q;
  assign sequence_error_o = res_err_q;
  assign list_full_o      = res_full_q;

endmodule

[sv/lps_ctrl.sv]
module lps_ctrl import lps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lps_status_t status_i,
  output lps_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_MUL,
    ST_MARK,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.seq_err ? ST_FINISH : ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = !status_i.walk_end;
        state_d     = status_i.walk_end ? ST_FINISH : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_MARK;
      end
      ST_MARK: begin
        cmd_o.mark = !status_i.prod_over;
        state_d    = status_i.prod_over ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        // The walk ends at the first stored prime that divides the candidate.
        if (status_i.rem_done) begin
          if (status_i.rem_zero) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = ST_FETCH;
          end
        end
      end
      ST_FINISH: begin
        cmd_o.finish = status_i.out_free;
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule
